FILE: rtl/triangle_unit_face_normal_assert.svh
// Assertion macros used by the checker module.
`ifndef TRIANGLE_UNIT_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_FACE_NORMAL_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define TUFN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define TUFN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/tufn_pkg.sv
package tufn_pkg;

    localparam int CoordW = 32;
    localparam int EdgeW  = 33;
    localparam int ProdW  = 66;
    localparam int CrossW = 67;
    localparam int MagW   = 66;
    localparam int NormW  = 30;
    localparam int SumW   = 62;
    localparam int LenW   = 31;
    localparam int QuoW   = 15;
    localparam int ShW    = 7;
    localparam logic [QuoW-1:0] UnitQ14 = 15'd16384;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [EdgeW-1:0]  edge_t;
    typedef logic signed [CrossW-1:0] cross_t;
    typedef logic [MagW-1:0]          mag_t;
    typedef logic [NormW-1:0]         norm_t;
    typedef logic [SumW-1:0]          sum_t;
    typedef logic [LenW-1:0]          len_t;
    typedef logic [QuoW-1:0]          quo_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } flags_t;

endpackage

FILE: rtl/tufn_cross.sv
module tufn_cross (
    input  logic            clk,
    input  logic            en,
    input  tufn_pkg::coord_t ax,
    input  tufn_pkg::coord_t ay,
    input  tufn_pkg::coord_t az,
    input  tufn_pkg::coord_t bx,
    input  tufn_pkg::coord_t by,
    input  tufn_pkg::coord_t bz,
    input  tufn_pkg::coord_t cx,
    input  tufn_pkg::coord_t cy,
    input  tufn_pkg::coord_t cz,
    output tufn_pkg::mag_t  mag_x,
    output tufn_pkg::mag_t  mag_y,
    output tufn_pkg::mag_t  mag_z,
    output tufn_pkg::flags_t flags
);
    import tufn_pkg::*;

    // Stage 1: edges. Stage 2: six products. Stage 3: differences.
    // Stage 4: sign and magnitude.
    edge_t e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [ProdW-1:0] p_reg [6];
    cross_t f_reg [3];
    mag_t   m_reg [3];
    flags_t fl_reg;
    logic [2:0] sg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1x_reg <= EdgeW'(bx) - EdgeW'(ax);
            e1y_reg <= EdgeW'(by) - EdgeW'(ay);
            e1z_reg <= EdgeW'(bz) - EdgeW'(az);
            e2x_reg <= EdgeW'(cx) - EdgeW'(ax);
            e2y_reg <= EdgeW'(cy) - EdgeW'(ay);
            e2z_reg <= EdgeW'(cz) - EdgeW'(az);
            p_reg[0] <= ProdW'(e1y_reg * e2z_reg);
            p_reg[1] <= ProdW'(e1z_reg * e2y_reg);
            p_reg[2] <= ProdW'(e1z_reg * e2x_reg);
            p_reg[3] <= ProdW'(e1x_reg * e2z_reg);
            p_reg[4] <= ProdW'(e1x_reg * e2y_reg);
            p_reg[5] <= ProdW'(e1y_reg * e2x_reg);
            for (int i = 0; i < 3; i++)
            begin
                f_reg[i] <= CrossW'(p_reg[2*i]) - CrossW'(p_reg[2*i+1]);
                m_reg[i] <= f_reg[i][CrossW-1] ? MagW'(-f_reg[i]) : MagW'(f_reg[i]);
            end
            fl_reg.neg   <= sg;
            fl_reg.degen <= (f_reg[0] == '0) && (f_reg[1] == '0) && (f_reg[2] == '0);
        end
    end

    assign sg = {f_reg[2][CrossW-1], f_reg[1][CrossW-1], f_reg[0][CrossW-1]};

    assign mag_x = m_reg[0];
    assign mag_y = m_reg[1];
    assign mag_z = m_reg[2];
    assign flags = fl_reg;
endmodule

FILE: rtl/tufn_norm.sv
module tufn_norm (
    input  logic             clk,
    input  logic             en,
    input  tufn_pkg::mag_t   mag_x,
    input  tufn_pkg::mag_t   mag_y,
    input  tufn_pkg::mag_t   mag_z,
    input  tufn_pkg::flags_t flags_in,
    output tufn_pkg::norm_t  ux,
    output tufn_pkg::norm_t  uy,
    output tufn_pkg::norm_t  uz,
    output tufn_pkg::sum_t   sum,
    output tufn_pkg::flags_t flags_out
);
    import tufn_pkg::*;

    // Stage A: bit length of the OR. Stage B: common shift. Stage C: squares.
    // Stage D: sum of squares.
    mag_t   ma_reg [3];
    logic [ShW-1:0] k_reg;
    flags_t fa_reg, fb_reg, fc_reg, fd_reg;
    norm_t  ub_reg [3], uc_reg [3], ud_reg [3];
    sum_t   sq_reg [3];
    sum_t   s_reg;
    mag_t   orv;
    logic [ShW-1:0] k_next;
    norm_t  u_next [3];

    assign orv = mag_x | mag_y | mag_z;

    always_comb
    begin
        k_next = '0;
        for (int i = 0; i < MagW; i++)
        begin
            if (orv[i])
            begin
                k_next = ShW'(i + 1);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (k_reg > ShW'(NormW))
            begin
                u_next[i] = NormW'(ma_reg[i] >> (k_reg - ShW'(NormW)));
            end
            else
            begin
                u_next[i] = NormW'(ma_reg[i] << (ShW'(NormW) - k_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg[0] <= mag_x;
            ma_reg[1] <= mag_y;
            ma_reg[2] <= mag_z;
            k_reg  <= k_next;
            fa_reg <= flags_in;
            fb_reg <= fa_reg;
            fc_reg <= fb_reg;
            fd_reg <= fc_reg;
            for (int i = 0; i < 3; i++)
            begin
                ub_reg[i] <= u_next[i];
                uc_reg[i] <= ub_reg[i];
                ud_reg[i] <= uc_reg[i];
                sq_reg[i] <= SumW'(ub_reg[i] * ub_reg[i]);
            end
            s_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign ux = ud_reg[0];
    assign uy = ud_reg[1];
    assign uz = ud_reg[2];
    assign sum = s_reg;
    assign flags_out = fd_reg;
endmodule

FILE: rtl/tufn_sqrt.sv
module tufn_sqrt (
    input  logic             clk,
    input  logic             en,
    input  tufn_pkg::norm_t  ux,
    input  tufn_pkg::norm_t  uy,
    input  tufn_pkg::norm_t  uz,
    input  tufn_pkg::sum_t   sum,
    input  tufn_pkg::flags_t flags_in,
    output tufn_pkg::norm_t  ux_out,
    output tufn_pkg::norm_t  uy_out,
    output tufn_pkg::norm_t  uz_out,
    output tufn_pkg::len_t   len,
    output tufn_pkg::flags_t flags_out
);
    import tufn_pkg::*;

    // One result bit per stage, restoring square root.
    localparam int Steps = LenW;

    sum_t   rem_reg [Steps+1];
    len_t   root_reg [Steps+1];
    norm_t  u_reg [Steps+1][3];
    flags_t f_reg [Steps+1];

    always_comb
    begin
        rem_reg[0]  = sum;
        root_reg[0] = '0;
        u_reg[0][0] = ux;
        u_reg[0][1] = uy;
        u_reg[0][2] = uz;
        f_reg[0]    = flags_in;
    end

    for (genvar s = 0; s < Steps; s++)
    begin : g_step
        localparam int B = Steps - 1 - s;
        logic [SumW+1:0] trial;
        assign trial = ({2'b00, SumW'(root_reg[s])} << (B + 1))
                       + ({2'b00, SumW'(1)} << (2 * B));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({2'b00, rem_reg[s]} >= trial)
                begin
                    rem_reg[s+1]  <= rem_reg[s] - SumW'(trial);
                    root_reg[s+1] <= root_reg[s] | (LenW'(1) << B);
                end
                else
                begin
                    rem_reg[s+1]  <= rem_reg[s];
                    root_reg[s+1] <= root_reg[s];
                end
                u_reg[s+1] <= u_reg[s];
                f_reg[s+1] <= f_reg[s];
            end
        end
    end

    assign ux_out = u_reg[Steps][0];
    assign uy_out = u_reg[Steps][1];
    assign uz_out = u_reg[Steps][2];
    assign len = (root_reg[Steps] == '0) ? LenW'(1) : root_reg[Steps];
    assign flags_out = f_reg[Steps];
endmodule

FILE: rtl/tufn_div.sv
module tufn_div (
    input  logic             clk,
    input  logic             en,
    input  tufn_pkg::norm_t  ux,
    input  tufn_pkg::norm_t  uy,
    input  tufn_pkg::norm_t  uz,
    input  tufn_pkg::len_t   len,
    input  tufn_pkg::flags_t flags_in,
    output logic signed [15:0] nx,
    output logic [14:0]      ny,
    output logic signed [15:0] nz,
    output logic             degenerate
);
    import tufn_pkg::*;

    // Quotient floor((u*32768 + L) / 2L), one bit per stage for three lanes.
    localparam int NumW = NormW + 16;
    localparam int DenW = LenW + 1;
    localparam int Steps = 16;

    logic [NumW-1:0] rem_reg [Steps+1][3];
    logic [DenW-1:0] den_reg [Steps+1];
    logic [Steps-1:0] q_reg [Steps+1][3];
    flags_t f_reg [Steps+1];
    logic [Steps-1:0] qf [3];
    logic [QuoW-1:0] qc [3];
    logic [15:0] sv [3];

    always_comb
    begin
        rem_reg[0][0] = (NumW'(ux) << 15) + NumW'(len);
        rem_reg[0][1] = (NumW'(uy) << 15) + NumW'(len);
        rem_reg[0][2] = (NumW'(uz) << 15) + NumW'(len);
        den_reg[0] = {len, 1'b0};
        for (int i = 0; i < 3; i++)
        begin
            q_reg[0][i] = '0;
        end
        f_reg[0] = flags_in;
    end

    for (genvar s = 0; s < Steps; s++)
    begin : g_step
        localparam int B = Steps - 1 - s;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if ((rem_reg[s][i] >> B) >= NumW'(den_reg[s]))
                    begin
                        rem_reg[s+1][i] <= rem_reg[s][i] - (NumW'(den_reg[s]) << B);
                        q_reg[s+1][i]   <= q_reg[s][i] | (Steps'(1) << B);
                    end
                    else
                    begin
                        rem_reg[s+1][i] <= rem_reg[s][i];
                        q_reg[s+1][i]   <= q_reg[s][i];
                    end
                end
                den_reg[s+1] <= den_reg[s];
                f_reg[s+1]   <= f_reg[s];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qf[i] = q_reg[Steps][i];
            qc[i] = (qf[i] > Steps'(UnitQ14)) ? UnitQ14 : QuoW'(qf[i]);
            sv[i] = (f_reg[Steps].neg[i] != f_reg[Steps].neg[1])
                    ? 16'(-{1'b0, qc[i]}) : {1'b0, qc[i]};
        end
    end

    assign nx = f_reg[Steps].degen ? '0 : sv[0];
    assign ny = f_reg[Steps].degen ? UnitQ14 : sv[1][14:0];
    assign nz = f_reg[Steps].degen ? '0 : sv[2];
    assign degenerate = f_reg[Steps].degen;
endmodule

FILE: rtl/triangle_unit_face_normal.sv
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid/in_ready   | ax..cz, 32-bit signed Q16.16
// out     | output    | out_valid/out_ready | nx, nz Q2.14, ny Q1.14, degenerate
// One request enters per cycle unless the output stalls.
// The depth is set by the bit-per-stage square root and the three-lane divider.
// Reset clears only the valid bits of the pipeline and the output register.
// A stall at the output freezes the whole pipeline; the output register holds its result.
module triangle_unit_face_normal (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tufn_pkg::coord_t ax,
    input  tufn_pkg::coord_t ay,
    input  tufn_pkg::coord_t az,
    input  tufn_pkg::coord_t bx,
    input  tufn_pkg::coord_t by,
    input  tufn_pkg::coord_t bz,
    input  tufn_pkg::coord_t cx,
    input  tufn_pkg::coord_t cy,
    input  tufn_pkg::coord_t cz,
    output logic             out_valid,
    input  logic             out_ready,
    output logic signed [15:0] nx,
    output logic [14:0]      ny,
    output logic signed [15:0] nz,
    output logic             degenerate
);
    import tufn_pkg::*;

    localparam int Depth = 4 + 4 + LenW + 16;

    logic [Depth-1:0] vld_reg;
    logic out_valid_reg;
    logic signed [15:0] nx_reg, nz_reg;
    logic [14:0] ny_reg;
    logic degen_reg;
    logic en;
    mag_t mx, my, mz;
    flags_t f1, f2, f3;
    norm_t ux, uy, uz, vx, vy, vz;
    sum_t sm;
    len_t ln;
    logic signed [15:0] dnx, dnz;
    logic [14:0] dny;
    logic ddeg;

    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Depth-2:0], in_valid};
            out_valid_reg <= vld_reg[Depth-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= dnx;
            ny_reg <= dny;
            nz_reg <= dnz;
            degen_reg <= ddeg;
        end
    end

    tufn_cross u_cross (
        .clk(clk), .en(en),
        .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
        .cx(cx), .cy(cy), .cz(cz),
        .mag_x(mx), .mag_y(my), .mag_z(mz), .flags(f1)
    );

    tufn_norm u_norm (
        .clk(clk), .en(en), .mag_x(mx), .mag_y(my), .mag_z(mz), .flags_in(f1),
        .ux(ux), .uy(uy), .uz(uz), .sum(sm), .flags_out(f2)
    );

    tufn_sqrt u_sqrt (
        .clk(clk), .en(en), .ux(ux), .uy(uy), .uz(uz), .sum(sm), .flags_in(f2),
        .ux_out(vx), .uy_out(vy), .uz_out(vz), .len(ln), .flags_out(f3)
    );

    tufn_div u_div (
        .clk(clk), .en(en), .ux(vx), .uy(vy), .uz(vz), .len(ln), .flags_in(f3),
        .nx(dnx), .ny(dny), .nz(dnz), .degenerate(ddeg)
    );

    assign out_valid = out_valid_reg;
    assign nx = nx_reg;
    assign ny = ny_reg;
    assign nz = nz_reg;
    assign degenerate = degen_reg;
endmodule

FILE: rtl/tufn_checker.sv
`include "triangle_unit_face_normal_assert.svh"

module tufn_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic signed [15:0] nx,
    input logic [14:0] ny,
    input logic signed [15:0] nz,
    input logic degenerate
);
    logic up_vec;

    assign up_vec = nx == 16'sd0 && nz == 16'sd0 && ny == 15'd16384;

    `TUFN_ASSERT_IMPL(a_degen_up, clk, rst_n, out_valid && degenerate, up_vec)
    `TUFN_ASSERT_IMPL(a_ny_range, clk, rst_n, out_valid, ny <= 15'd16384)
    `TUFN_ASSERT_IMPL(a_nx_range, clk, rst_n, out_valid, nx <= 16'sd16384 && nx >= -16'sd16384)
    `TUFN_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(nx) && $stable(ny))
endmodule

bind triangle_unit_face_normal tufn_checker u_tufn_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .nx(nx), .ny(ny), .nz(nz), .degenerate(degenerate)
);

FILE: sim/tb_triangle_unit_face_normal.sv
module tb_triangle_unit_face_normal;
    timeunit 1ns;
    timeprecision 1ps;

    import tufn_pkg::*;

    localparam int Latency = 56;
    localparam int WatchdogLimit = 4000;

    typedef struct {
        logic signed [15:0] nx;
        logic [14:0]        ny;
        logic signed [15:0] nz;
        logic               degenerate;
    } normal_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    coord_t ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0, cx = '0, cy = '0, cz = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] nx;
    logic [14:0] ny;
    logic signed [15:0] nz;
    logic degenerate;

    normal_t expected_normals[$];
    int errors = 0;
    int requests_sent = 0;
    int normals_seen = 0;
    int degenerate_seen = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit sink_stalls = 1'b1;
    bit source_gaps = 1'b1;

    triangle_unit_face_normal dut (.*);

    always #5 clk = ~clk;

    function automatic int unsigned bit_length(logic [66:0] v);
        int unsigned n;
        n = 0;
        for (int i = 0; i < 67; i++)
            if (v[i])
                n = i + 1;
        return n;
    endfunction

    function automatic logic [30:0] int_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root[30:0];
    endfunction

    function automatic normal_t face_normal(coord_t pa[3], coord_t pb[3], coord_t pc[3]);
        logic signed [66:0] e1[3];
        logic signed [66:0] e2[3];
        logic signed [66:0] f[3];
        logic [66:0] m[3];
        logic [63:0] u[3];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        logic [15:0] r[3];
        logic [66:0] orv;
        int unsigned k;
        normal_t n;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = 67'(pb[i]) - 67'(pa[i]);
            e2[i] = 67'(pc[i]) - 67'(pa[i]);
        end
        f[0] = e1[1] * e2[2] - e1[2] * e2[1];
        f[1] = e1[2] * e2[0] - e1[0] * e2[2];
        f[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int i = 0; i < 3; i++)
            m[i] = f[i][66] ? 67'(-f[i]) : 67'(f[i]);
        orv = m[0] | m[1] | m[2];
        k = bit_length(orv);
        if (k == 0)
        begin
            n.nx = '0;
            n.ny = UnitQ14;
            n.nz = '0;
            n.degenerate = 1'b1;
            return n;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (k > 30)
                u[i] = 64'(m[i] >> (k - 30));
            else
                u[i] = 64'(m[i] << (30 - k));
            u[i] = u[i] & 64'h3FFF_FFFF;
        end
        sum = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        len = 64'(int_sqrt(sum));
        if (len == 0)
            len = 1;
        for (int i = 0; i < 3; i++)
        begin
            q = (u[i] * 64'd32768 + len) / (64'd2 * len);
            if (q > 16384)
                q = 16384;
            r[i] = (f[i][66] != f[1][66]) ? 16'(-q) : q[15:0];
        end
        n.nx = r[0];
        n.ny = r[1][14:0];
        n.nz = r[2];
        n.degenerate = 1'b0;
        return n;
    endfunction

    task automatic send_triangle(coord_t pa[3], coord_t pb[3], coord_t pc[3]);
        if (source_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        expected_normals.insert(expected_normals.size(), face_normal(pa, pb, pc));
        in_valid <= 1'b1;
        ax <= pa[0]; ay <= pa[1]; az <= pa[2];
        bx <= pb[0]; by <= pb[1]; bz <= pb[2];
        cx <= pc[0]; cy <= pc[1]; cz <= pc[2];
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    function automatic coord_t random_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 255)) - 128;
            2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return coord_t'(int'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000);
        endcase
    endfunction

    task automatic test_directed();
        coord_t pa[3], pb[3], pc[3];
        coord_t maxv, minv;
        maxv = 32'sh7FFF_FFFF;
        minv = 32'sh8000_0000;
        pa = '{0, 0, 0}; pb = '{0, 0, 0}; pc = '{0, 0, 0};
        send_triangle(pa, pb, pc);
        pb = '{65536, 0, 0}; pc = '{131072, 0, 0};
        send_triangle(pa, pb, pc);
        pb = '{65536, 0, 0}; pc = '{0, 0, 65536};
        send_triangle(pa, pb, pc);
        pb = '{0, 0, 65536}; pc = '{65536, 0, 0};
        send_triangle(pa, pb, pc);
        pb = '{0, 65536, 0}; pc = '{0, 0, 65536};
        send_triangle(pa, pb, pc);
        pb = '{65536, 0, 0}; pc = '{0, 65536, 0};
        send_triangle(pa, pb, pc);
        pa = '{minv, minv, minv}; pb = '{maxv, minv, minv}; pc = '{minv, minv, maxv};
        send_triangle(pa, pb, pc);
        pa = '{maxv, maxv, maxv}; pb = '{minv, maxv, maxv}; pc = '{maxv, minv, minv};
        send_triangle(pa, pb, pc);
        pa = '{minv, maxv, minv}; pb = '{maxv, minv, maxv}; pc = '{minv, minv, maxv};
        send_triangle(pa, pb, pc);
        pa = '{0, 0, 0}; pb = '{1, 0, 0}; pc = '{0, 0, 1};
        send_triangle(pa, pb, pc);
        pb = '{1, 1, 0}; pc = '{1000, 0, 1};
        send_triangle(pa, pb, pc);
        pa = '{-1, -1, -1}; pb = '{maxv, 0, 5}; pc = '{7, maxv, minv};
        send_triangle(pa, pb, pc);
        pa = '{maxv, maxv, maxv}; pb = '{maxv, maxv, maxv}; pc = '{maxv, maxv, maxv};
        send_triangle(pa, pb, pc);
    endtask

    task automatic test_random(int count);
        coord_t pa[3], pb[3], pc[3];
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa[i] = random_coord();
                pb[i] = random_coord();
                pc[i] = random_coord();
            end
            case ($urandom_range(0, 9))
                0: pc = pb;
                1: for (int i = 0; i < 3; i++) pc[i] = pa[i] + 2 * (pb[i] - pa[i]);
                2: pb[1] = pa[1];
                3: begin pb[1] = pa[1]; pc[1] = pa[1]; end
                default: ;
            endcase
            send_triangle(pa, pb, pc);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (sink_stalls && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 15);
        out_ready <= (stall_left == 0);
    end

    always @(posedge clk)
    begin
        normal_t e;
        if (rst_n && out_valid && out_ready)
        begin
            normals_seen++;
            if (expected_normals.size() == 0)
            begin
                $error("normal produced with no request pending");
                errors++;
            end
            else
            begin
                e = expected_normals.pop_front();
                if (degenerate) degenerate_seen++;
                if (nx !== e.nx)
                begin
                    $error("nx expected %0d actual %0d", e.nx, nx);
                    errors++;
                end
                if (ny !== e.ny)
                begin
                    $error("ny expected %0d actual %0d", e.ny, ny);
                    errors++;
                end
                if (nz !== e.nz)
                begin
                    $error("nz expected %0d actual %0d", e.nz, nz);
                    errors++;
                end
                if (degenerate !== e.degenerate)
                begin
                    $error("degenerate expected %0d actual %0d", e.degenerate, degenerate);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("[triangle_unit_face_normal] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(380);
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random(70);
        in_valid <= 1'b0;
        while (expected_normals.size() != 0)
            @(posedge clk);
        repeat (Latency + 10) @(posedge clk);
        $display("Sent %0d triangles, checked %0d normals, %0d of them degenerate.",
                 requests_sent, normals_seen, degenerate_seen);
        if (errors == 0)
            $display("[triangle_unit_face_normal] OK");
        else
            $display("[triangle_unit_face_normal] ERROR");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/tufn_pkg.sv
rtl/tufn_cross.sv
rtl/tufn_norm.sv
rtl/tufn_sqrt.sv
rtl/tufn_div.sv
rtl/triangle_unit_face_normal.sv
rtl/tufn_checker.sv
sim/tb_triangle_unit_face_normal.sv
